// ----- rtl/core/countdown_blind_raise_timer_unit_macros.svh -----
// ----------------------------------------------------------------------------
// countdown blind raise timer assertion macros
// shared property wrappers for the timer checks
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_BLIND_RAISE_TIMER_UNIT_MACROS_SVH
`define COUNTDOWN_BLIND_RAISE_TIMER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CBRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CBRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/cbrt_pkg.sv -----
// ----------------------------------------------------------------------------
// cbrt_pkg
// phase codes, key lock codes and register indexes of the blind raise timer
// ----------------------------------------------------------------------------
package cbrt_pkg;

  // phase codes
  localparam logic [2:0] PH_SETTING = 3'd0;
  localparam logic [2:0] PH_CONFIRM = 3'd1;
  localparam logic [2:0] PH_COUNT   = 3'd2;
  localparam logic [2:0] PH_ABORT   = 3'd3;
  localparam logic [2:0] PH_RELEASE = 3'd4;
  localparam logic [2:0] PH_RAISE   = 3'd5;

  // key lock codes
  localparam logic [1:0] KL_NONE = 2'd0;
  localparam logic [1:0] KL_HELD = 2'd1;
  localparam logic [1:0] KL_DEB  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_RAISE_SECONDS = 3'd0;
  localparam logic [2:0] REG_TICKS_PER_HS  = 3'd1;
  localparam logic [2:0] REG_DEBOUNCE      = 3'd2;
  localparam logic [2:0] REG_IDLE_LOCKIN   = 3'd3;
  localparam logic [2:0] REG_HS_PER_MINUTE = 3'd4;
  localparam logic [2:0] REG_MIN_PER_STEP  = 3'd5;
  localparam logic [2:0] REG_LARGE_STEP    = 3'd6;

  // flash length of confirm and abort, in half-seconds
  localparam logic [4:0] FLASH_HALFSECS = 5'd8;
  localparam logic [3:0] IDLE_MAX       = 4'd15;

endpackage

// ----- rtl/core/countdown_blind_raise_timer_unit.sv -----
// ----------------------------------------------------------------------------
// countdown_blind_raise_timer_unit
// blind timer: key entry of a half-hour count, confirm flash, countdown,
// abort flash and, with a nonzero raise time, a timed raise of the motor at expiry
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in_     | in_valid, in_stall  | key_small, key_big, go_up, go_down
//  out_    | out_valid, out_stall| drive_up, drive_down, indicator, phase
//  cfg_    | cfg_valid, cfg_ready| cfg_index (3), cfg_data (8)
//
//  one tick per cycle while in_valid and not in_stall: each transfer is handled
//  in a single pass of logic from the state registers into the result register.
//  in_stall is high only while a result waits and out_stall holds it.
//  synchronous active-low reset clears state, the config to its defaults
//  and the result valid; cfg_ready is always high.
`include "countdown_blind_raise_timer_unit_macros.svh"

module countdown_blind_raise_timer_unit
  import cbrt_pkg::*;
#(
  parameter int COUNT_BITS = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_key_small,
  input  logic       in_key_big,
  input  logic       in_go_up,
  input  logic       in_go_down,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_drive_up,
  output logic       out_drive_down,
  output logic [4:0] out_indicator,
  output logic [2:0] out_phase,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // configuration registers
  logic [3:0] raise_sec_r;
  logic [7:0] tph_r;
  logic [7:0] deb_r;
  logic [3:0] idle_lim_r;
  logic [6:0] hspm_r;
  logic [5:0] mps_r;
  logic [4:0] large_r;

  // timer state
  logic [2:0]            phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] hh_r, hh_nxt;
  logic [7:0]            tick_r, tick_nxt;
  logic [3:0]            idle_r, idle_nxt;
  logic [6:0]            hsc_r, hsc_nxt;
  logic [5:0]            minc_r, minc_nxt;
  logic [4:0]            step_r, step_nxt;
  logic [1:0]            kl_r, kl_nxt;

  // result register
  logic       out_valid_r;
  logic       mup_r, mdn_r;
  logic [4:0] ind_r;
  logic [2:0] ph_r;
  logic       mup_nxt, mdn_nxt;
  logic [4:0] ind_nxt;
  logic [2:0] ph_nxt;

  logic in_xfer;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_xfer   = in_valid & ~in_stall;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raise_sec_r <= 4'd0;
      tph_r       <= 8'd210;
      deb_r       <= 8'd30;
      idle_lim_r  <= 4'd10;
      hspm_r      <= 7'd120;
      mps_r       <= 6'd30;
      large_r     <= 5'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RAISE_SECONDS: raise_sec_r <= cfg_data[3:0];
        REG_TICKS_PER_HS:  tph_r       <= cfg_data;
        REG_DEBOUNCE:      deb_r       <= cfg_data;
        REG_IDLE_LOCKIN:   idle_lim_r  <= cfg_data[3:0];
        REG_HS_PER_MINUTE: hspm_r      <= cfg_data[6:0];
        REG_MIN_PER_STEP:  mps_r       <= cfg_data[5:0];
        REG_LARGE_STEP:    large_r     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // next state and result of one tick
  logic [7:0]            t_inc;
  logic                  hs_el;
  logic                  any_key;
  logic [COUNT_BITS+4:0] hh_ext;
  logic [COUNT_BITS+4:0] large_ext;
  logic [5:0]            raise_lim;

  assign t_inc     = tick_r + 8'd1;
  assign hs_el     = (t_inc >= tph_r);
  assign any_key   = in_go_up | in_go_down | in_key_small | in_key_big;
  assign large_ext = {{COUNT_BITS{1'b0}}, large_r};
  assign raise_lim = {1'b0, raise_sec_r, 1'b0};

  always_comb begin
    phase_nxt = phase_r;
    hh_nxt    = hh_r;
    tick_nxt  = tick_r;
    idle_nxt  = idle_r;
    hsc_nxt   = hsc_r;
    minc_nxt  = minc_r;
    step_nxt  = step_r;
    kl_nxt    = kl_r;
    mup_nxt   = 1'b0;
    mdn_nxt   = 1'b0;
    ind_nxt   = 5'd0;
    ph_nxt    = phase_r;
    hh_ext    = '0;
    unique case (phase_r)
      PH_SETTING: begin
        if (kl_r == KL_HELD) begin
          idle_nxt = 4'd0;
          if (!in_key_small && !in_key_big) begin
            kl_nxt   = (deb_r == 8'd0) ? KL_NONE : KL_DEB;
            tick_nxt = 8'd0;
          end
        end else if (kl_r == KL_DEB) begin
          idle_nxt = 4'd0;
          tick_nxt = t_inc;
          if (t_inc >= deb_r) begin
            kl_nxt   = KL_NONE;
            tick_nxt = 8'd0;
          end
        end else begin
          kl_nxt = KL_NONE;
          if (any_key) begin
            if (in_go_up) begin
              mup_nxt = 1'b1;
            end else if (in_go_down) begin
              mdn_nxt = 1'b1;
            end else begin
              hh_nxt = in_key_small ? hh_r + COUNT_BITS'(1)
                                    : hh_r + large_ext[COUNT_BITS-1:0];
              kl_nxt = KL_HELD;
            end
            tick_nxt = 8'd0;
            idle_nxt = 4'd0;
          end else if (hs_el) begin
            tick_nxt = 8'd0;
            if (idle_r < IDLE_MAX) idle_nxt = idle_r + 4'd1;
          end else begin
            tick_nxt = t_inc;
          end
        end
        // lock-in once idle long enough with a count set
        if (kl_nxt == KL_NONE && hh_nxt != '0 && idle_nxt >= idle_lim_r) begin
          phase_nxt = PH_CONFIRM;
          tick_nxt  = 8'd0;
          step_nxt  = 5'd0;
        end
        hh_ext  = {5'd0, hh_nxt};
        ind_nxt = hh_ext[4:0];
      end
      PH_CONFIRM: begin
        hh_ext  = {5'd0, hh_r};
        ind_nxt = step_r[0] ? 5'd0 : hh_ext[4:0];
        tick_nxt = hs_el ? 8'd0 : t_inc;
        if (hs_el) begin
          step_nxt = step_r + 5'd1;
          if (step_r + 5'd1 >= FLASH_HALFSECS) begin
            phase_nxt = PH_COUNT;
            tick_nxt  = 8'd0;
            hsc_nxt   = 7'd0;
            minc_nxt  = 6'd0;
            step_nxt  = 5'd0;
          end
        end
      end
      PH_COUNT: begin
        if (in_go_up || in_go_down) begin
          phase_nxt = PH_ABORT;
          tick_nxt  = 8'd0;
          step_nxt  = 5'd0;
        end else if (hs_el) begin
          tick_nxt = 8'd0;
          hsc_nxt  = hsc_r + 7'd1;
          if (hsc_r + 7'd1 >= hspm_r) begin
            hsc_nxt  = 7'd0;
            minc_nxt = minc_r + 6'd1;
          end
          if (minc_nxt >= mps_r) begin
            minc_nxt = 6'd0;
            hh_nxt   = hh_r - COUNT_BITS'(1);
            if (hh_nxt == '0) begin
              tick_nxt = 8'd0;
              step_nxt = 5'd0;
              if (raise_sec_r == 4'd0) begin
                phase_nxt = PH_SETTING;
                idle_nxt  = 4'd0;
                kl_nxt    = KL_NONE;
              end else begin
                phase_nxt = PH_RAISE;
              end
            end
          end
        end else begin
          tick_nxt = t_inc;
        end
        hh_ext  = {5'd0, hh_nxt};
        ind_nxt = hh_ext[4:0];
      end
      PH_ABORT: begin
        ind_nxt  = step_r[0] ? 5'd0 : 5'h1f;
        tick_nxt = hs_el ? 8'd0 : t_inc;
        if (hs_el) begin
          step_nxt = step_r + 5'd1;
          if (step_r + 5'd1 >= FLASH_HALFSECS) begin
            phase_nxt = PH_RELEASE;
            hh_nxt    = '0;
            step_nxt  = 5'd0;
          end
        end
      end
      PH_RELEASE: begin
        if (!in_go_up && !in_go_down) begin
          phase_nxt = PH_SETTING;
          tick_nxt  = 8'd0;
          idle_nxt  = 4'd0;
          kl_nxt    = KL_NONE;
          step_nxt  = 5'd0;
        end
      end
      PH_RAISE: begin
        mup_nxt  = 1'b1;
        ind_nxt  = step_r[0] ? 5'd0 : 5'd1;
        tick_nxt = hs_el ? 8'd0 : t_inc;
        if (hs_el) step_nxt = step_r + 5'd1;
        if ({1'b0, step_nxt} >= raise_lim) begin
          phase_nxt = PH_SETTING;
          tick_nxt  = 8'd0;
          idle_nxt  = 4'd0;
          kl_nxt    = KL_NONE;
          step_nxt  = 5'd0;
        end
      end
      default: begin
        // unused phase code: back to setting with everything cleared
        hh_nxt    = '0;
        hsc_nxt   = 7'd0;
        minc_nxt  = 6'd0;
        phase_nxt = PH_SETTING;
        tick_nxt  = 8'd0;
        idle_nxt  = 4'd0;
        kl_nxt    = KL_NONE;
        step_nxt  = 5'd0;
        ph_nxt    = PH_SETTING;
      end
    endcase
  end

  // state update on an input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SETTING;
      hh_r    <= '0;
      tick_r  <= 8'd0;
      idle_r  <= 4'd0;
      hsc_r   <= 7'd0;
      minc_r  <= 6'd0;
      step_r  <= 5'd0;
      kl_r    <= KL_NONE;
    end else if (in_xfer) begin
      phase_r <= phase_nxt;
      hh_r    <= hh_nxt;
      tick_r  <= tick_nxt;
      idle_r  <= idle_nxt;
      hsc_r   <= hsc_nxt;
      minc_r  <= minc_nxt;
      step_r  <= step_nxt;
      kl_r    <= kl_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mup_r <= mup_nxt;
      mdn_r <= mdn_nxt;
      ind_r <= ind_nxt;
      ph_r  <= ph_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_drive_up   = mup_r;
  assign out_drive_down = mdn_r;
  assign out_indicator  = ind_r;
  assign out_phase      = ph_r;

  // checks
  `CBRT_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid_r,
    "input stalled with no result pending")
  `CBRT_ASSERT_NOW(a_motor_exclusive, out_valid_r, !(mup_r && mdn_r),
    "motor driven up and down at once")
  `CBRT_ASSERT_NOW(a_lock_only_in_setting, kl_r != KL_NONE, phase_r == PH_SETTING,
    "key lock active outside the setting phase")
  `CBRT_ASSERT_NEXT(a_lockin_nonzero,
    in_xfer && phase_r == PH_SETTING && phase_nxt == PH_CONFIRM, hh_r != '0,
    "locked in with a zero count")

endmodule
